/* rtl/core/csh_pkg.sv */
// Package with the shared widths, codes and types of the cross stencil height smoother.
package csh_pkg;

  localparam int SAMPLE_W      = 8;
  localparam int NUM_COLS_W    = 6;
  localparam int NUM_ROWS_W    = 13;
  localparam int ROW_CNT_W     = 12;
  localparam int WEIGHT_W      = 4;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 13;
  localparam int SUM_W         = 13;
  localparam int DIVISOR_W     = 5;
  localparam int ROW_LIMIT     = 4096;

  localparam logic [CFG_INDEX_W-1:0] CFG_NUM_COLS      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_NUM_ROWS      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_WEIGHT = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_C,
    ST_RD_L,
    ST_RD_R,
    ST_ADD_R,
    ST_ADD_V,
    ST_ADD_D,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUT,
    ST_WR
  } csh_state_t;

  typedef struct packed {
    logic                done;
    logic [SAMPLE_W-1:0] quotient;
  } csh_div_res_t;

endpackage

/* rtl/core/cross_stencil_height_smoother_core.sv */
// Top level of the cross stencil height smoother: sequencer, accumulator and line stores.
//
//   Channel  Direction  Handshake           Payload
//   in_      input      in_valid/in_stall   in_sample
//   out_     output     out_valid/out_stall out_smoothed, out_last_cell
//   cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// A first-row input is only written to a line store; a later one takes three line store
// reads, up to four adds through one shared adder and the 8-step divider. The last input
// of a grid also flushes the last row through them. Synchronous reset clears position
// and configuration; line stores stay undefined until written. A result waits in the
// output register under out_stall; the sequencer stalls only when the next result is
// ready before that transfer.
module cross_stencil_height_smoother_core
  import csh_pkg::*;
#(
  parameter int MAX_COLS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_W-1:0]    in_sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SAMPLE_W-1:0]    out_smoothed,
  output logic                   out_last_cell,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int ADDR_W = $clog2(MAX_COLS);
  localparam int CW     = NUM_COLS_W + 1;
  localparam int RW     = NUM_ROWS_W + 1;

  csh_state_t state_r, state_nxt;

  logic [NUM_COLS_W-1:0] num_cols_r;
  logic [NUM_ROWS_W-1:0] num_rows_r;
  logic [WEIGHT_W-1:0]   weight_r;

  logic [ADDR_W-1:0]     col_count_r, col_count_nxt;
  logic [ROW_CNT_W-1:0]  row_count_r, row_count_nxt;
  logic                  bank_sel_r, bank_sel_nxt;
  logic                  flush_r, flush_nxt;
  logic [ADDR_W-1:0]     c_r, c_nxt;
  logic [ROW_CNT_W-1:0]  r_r, r_nxt;
  logic [ADDR_W-1:0]     k_r, k_nxt;
  logic [SAMPLE_W-1:0]   s_r, s_nxt;
  logic [SAMPLE_W-1:0]   vert_r, vert_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [DIVISOR_W-1:0]  dsr_r, dsr_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0]   smoothed_r, smoothed_nxt;
  logic                  last_r, last_nxt;

  logic [NUM_COLS_W-1:0] cols_eff;
  logic [NUM_ROWS_W-1:0] rows_eff;
  logic [ADDR_W-1:0]     c_in;
  logic [ROW_CNT_W-1:0]  r_in;
  logic                  has_left;
  logic                  has_right;
  logic                  has_up;
  logic                  row_end;
  logic                  grid_end;
  logic                  out_free;

  logic [ADDR_W-1:0]     ram_raddr;
  logic                  wr_en;
  logic [SAMPLE_W-1:0]   a_q;
  logic [SAMPLE_W-1:0]   b_q;
  logic [SAMPLE_W-1:0]   prev_q;
  logic [SAMPLE_W-1:0]   curr_q;
  logic [SAMPLE_W-1:0]   centre_q;
  logic [SAMPLE_W-1:0]   side_q;
  logic                  add_en;
  logic [SAMPLE_W-1:0]   add_term;
  logic                  div_start;
  csh_div_res_t          div_res;

  always_comb begin
    if (num_cols_r == '0) begin
      cols_eff = NUM_COLS_W'(1);
    end else if (num_cols_r > NUM_COLS_W'(MAX_COLS)) begin
      cols_eff = NUM_COLS_W'(MAX_COLS);
    end else begin
      cols_eff = num_cols_r;
    end
    if (num_rows_r == '0) begin
      rows_eff = NUM_ROWS_W'(1);
    end else if (num_rows_r > NUM_ROWS_W'(ROW_LIMIT)) begin
      rows_eff = NUM_ROWS_W'(ROW_LIMIT);
    end else begin
      rows_eff = num_rows_r;
    end
  end

  assign c_in = (NUM_COLS_W'(col_count_r) >= cols_eff) ?
                ADDR_W'(cols_eff - NUM_COLS_W'(1)) : col_count_r;
  assign r_in = (NUM_ROWS_W'(row_count_r) >= rows_eff) ?
                ROW_CNT_W'(rows_eff - NUM_ROWS_W'(1)) : row_count_r;

  assign has_left  = (k_r != '0);
  assign has_right = (CW'(k_r) + CW'(1)) < CW'(cols_eff);
  assign has_up    = flush_r ? (r_r != '0) : (r_r >= ROW_CNT_W'(2));
  assign row_end   = (CW'(c_r) + CW'(1)) >= CW'(cols_eff);
  assign grid_end  = (RW'(r_r) + RW'(1)) >= RW'(rows_eff);
  assign out_free  = !out_valid_r || !out_stall;

  assign prev_q   = bank_sel_r ? b_q : a_q;
  assign curr_q   = bank_sel_r ? a_q : b_q;
  assign centre_q = flush_r ? curr_q : prev_q;
  assign side_q   = flush_r ? curr_q : prev_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cols_r <= NUM_COLS_W'(32);
      num_rows_r <= NUM_ROWS_W'(32);
      weight_r   <= WEIGHT_W'(4);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NUM_COLS:      num_cols_r <= cfg_data[NUM_COLS_W-1:0];
        CFG_NUM_ROWS:      num_rows_r <= cfg_data[NUM_ROWS_W-1:0];
        CFG_CENTER_WEIGHT: weight_r   <= cfg_data[WEIGHT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      col_count_r <= '0;
      row_count_r <= '0;
      bank_sel_r  <= 1'b0;
      flush_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_count_r <= col_count_nxt;
      row_count_r <= row_count_nxt;
      bank_sel_r  <= bank_sel_nxt;
      flush_r     <= flush_nxt;
      out_valid_r <= out_valid_nxt;
    end
    c_r        <= c_nxt;
    r_r        <= r_nxt;
    k_r        <= k_nxt;
    s_r        <= s_nxt;
    vert_r     <= vert_nxt;
    sum_r      <= sum_nxt;
    dsr_r      <= dsr_nxt;
    smoothed_r <= smoothed_nxt;
    last_r     <= last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    col_count_nxt = col_count_r;
    row_count_nxt = row_count_r;
    bank_sel_nxt  = bank_sel_r;
    flush_nxt     = flush_r;
    c_nxt         = c_r;
    r_nxt         = r_r;
    k_nxt         = k_r;
    s_nxt         = s_r;
    vert_nxt      = vert_r;
    sum_nxt       = sum_r;
    dsr_nxt       = dsr_r;
    out_valid_nxt = out_valid_r && out_stall;
    smoothed_nxt  = smoothed_r;
    last_nxt      = last_r;
    ram_raddr     = k_r;
    wr_en         = 1'b0;
    add_en        = 1'b0;
    add_term      = side_q;
    div_start     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          s_nxt     = in_sample;
          c_nxt     = c_in;
          r_nxt     = r_in;
          k_nxt     = c_in;
          flush_nxt = 1'b0;
          state_nxt = (r_in != '0) ? ST_RD_C : ST_WR;
        end
      end
      ST_RD_C: begin
        ram_raddr = k_r;
        state_nxt = ST_RD_L;
      end
      ST_RD_L: begin
        ram_raddr = has_left ? ADDR_W'(k_r - ADDR_W'(1)) : k_r;
        sum_nxt   = SUM_W'(weight_r) * SUM_W'(centre_q);
        dsr_nxt   = DIVISOR_W'(weight_r);
        vert_nxt  = flush_r ? prev_q : curr_q;
        state_nxt = ST_RD_R;
      end
      ST_RD_R: begin
        ram_raddr = has_right ? ADDR_W'(k_r + ADDR_W'(1)) : k_r;
        add_en    = has_left;
        add_term  = side_q;
        state_nxt = ST_ADD_R;
      end
      ST_ADD_R: begin
        add_en    = has_right;
        add_term  = side_q;
        state_nxt = ST_ADD_V;
      end
      ST_ADD_V: begin
        add_en    = has_up;
        add_term  = vert_r;
        state_nxt = flush_r ? ST_DIV_GO : ST_ADD_D;
      end
      ST_ADD_D: begin
        add_en    = 1'b1;
        add_term  = s_r;
        state_nxt = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_res.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          smoothed_nxt  = div_res.quotient;
          last_nxt      = flush_r && !has_right;
          if (!flush_r) begin
            state_nxt = ST_WR;
          end else if (!has_right) begin
            col_count_nxt = '0;
            row_count_nxt = '0;
            flush_nxt     = 1'b0;
            state_nxt     = ST_IDLE;
          end else begin
            k_nxt     = ADDR_W'(k_r + ADDR_W'(1));
            state_nxt = ST_RD_C;
          end
        end
      end
      ST_WR: begin
        wr_en = 1'b1;
        if (row_end) begin
          if (grid_end) begin
            flush_nxt = 1'b1;
            k_nxt     = '0;
            state_nxt = ST_RD_C;
          end else begin
            bank_sel_nxt  = !bank_sel_r;
            col_count_nxt = '0;
            row_count_nxt = ROW_CNT_W'(r_r + ROW_CNT_W'(1));
            state_nxt     = ST_IDLE;
          end
        end else begin
          col_count_nxt = ADDR_W'(c_r + ADDR_W'(1));
          row_count_nxt = r_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (add_en) begin
      sum_nxt = SUM_W'(sum_r + SUM_W'(add_term));
      dsr_nxt = DIVISOR_W'(dsr_r + DIVISOR_W'(1));
    end
  end

  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_smoothed  = smoothed_r;
  assign out_last_cell = last_r;

  csh_line_ram #(
    .DEPTH  (MAX_COLS),
    .ADDR_W (ADDR_W)
  ) u_bank_a (
    .clk   (clk),
    .we    (wr_en && bank_sel_r),
    .waddr (c_r),
    .wdata (s_r),
    .raddr (ram_raddr),
    .rdata (a_q)
  );

  csh_line_ram #(
    .DEPTH  (MAX_COLS),
    .ADDR_W (ADDR_W)
  ) u_bank_b (
    .clk   (clk),
    .we    (wr_en && !bank_sel_r),
    .waddr (c_r),
    .wdata (s_r),
    .raddr (ram_raddr),
    .rdata (b_q)
  );

  csh_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (dsr_r),
    .res      (div_res)
  );

endmodule

/* rtl/core/csh_line_ram.sv */
// Line store memory with one write port and one registered read port.
module csh_line_ram
  import csh_pkg::*;
#(
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5
) (
  input  logic                clk,
  input  logic                we,
  input  logic [ADDR_W-1:0]   waddr,
  input  logic [SAMPLE_W-1:0] wdata,
  input  logic [ADDR_W-1:0]   raddr,
  output logic [SAMPLE_W-1:0] rdata
);

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/csh_divider.sv */
// Restoring divider that yields an 8-bit quotient one bit per cycle.
module csh_divider
  import csh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [SUM_W-1:0]     dividend,
  input  logic [DIVISOR_W-1:0] divisor,
  output csh_div_res_t         res
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [2:0]           cnt_r, cnt_nxt;
  logic [DIVISOR_W-1:0] rem_r, rem_nxt;
  logic [SAMPLE_W-1:0]  quo_r, quo_nxt;
  logic [DIVISOR_W-1:0] dsr_r, dsr_nxt;
  logic [DIVISOR_W:0]   trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    trial    = {rem_r, quo_r[SAMPLE_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 3'd7;
      rem_nxt  = dividend[SUM_W-1:SAMPLE_W];
      quo_nxt  = dividend[SAMPLE_W-1:0];
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = DIVISOR_W'(trial - {1'b0, dsr_r});
        quo_nxt = {quo_r[SAMPLE_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIVISOR_W-1:0];
        quo_nxt = {quo_r[SAMPLE_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 3'd1;
      if (cnt_r == 3'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // A zero divisor only arises with no neighbors and no center weight; it gives zero.
  assign res.done     = done_r;
  assign res.quotient = (dsr_r == '0) ? '0 : quo_r;

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the cross stencil height smoother core.
module tb;
  import csh_pkg::*;

  localparam int LINE_CELLS   = 32;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [SAMPLE_W-1:0] smoothed;
    logic                last_cell;
  } cell_result_t;

  typedef enum {FILL_RANDOM, FILL_MAX, FILL_ZERO, FILL_CHECKER} fill_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [SAMPLE_W-1:0]    in_sample = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [SAMPLE_W-1:0]    out_smoothed;
  logic                   out_last_cell;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_output = 1'b0;
  int error_count = 0;
  int cycle_count = 0;

  // Predictor state.
  logic [NUM_COLS_W-1:0] pred_cols = 6'd32;
  logic [NUM_ROWS_W-1:0] pred_rows = 13'd32;
  logic [WEIGHT_W-1:0]   pred_weight = 4'd4;
  logic [SAMPLE_W-1:0]   prev_line [LINE_CELLS];
  logic [SAMPLE_W-1:0]   curr_line [LINE_CELLS];
  int next_col = 0;
  int next_row = 0;
  cell_result_t pending_cells [$];
  cell_result_t want;

  cross_stencil_height_smoother_core #(.MAX_COLS(LINE_CELLS)) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_smoothed (out_smoothed),
    .out_last_cell(out_last_cell),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** cross_stencil_height_smoother_core: FAILED **");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= hold_output || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_cells.size() == 0) begin
        $error("result transfer with nothing expected: smoothed %0d last_cell %0b",
               out_smoothed, out_last_cell);
        error_count++;
      end else begin
        want = pending_cells.pop_front();
        if (out_smoothed !== want.smoothed) begin
          $error("smoothed: expected %0d, actual %0d", want.smoothed, out_smoothed);
          error_count++;
        end
        if (out_last_cell !== want.last_cell) begin
          $error("last_cell: expected %0b, actual %0b", want.last_cell, out_last_cell);
          error_count++;
        end
      end
    end
  end

  function automatic void queue_expected(input cell_result_t item);
    pending_cells.insert(pending_cells.size(), item);
  endfunction

  function automatic int cols_in_use();
    if (pred_cols == 0) return 1;
    if (pred_cols > LINE_CELLS) return LINE_CELLS;
    return pred_cols;
  endfunction

  function automatic int rows_in_use();
    if (pred_rows == 0) return 1;
    if (pred_rows > ROW_LIMIT) return ROW_LIMIT;
    return pred_rows;
  endfunction

  // present bits: left, right, up, down.
  function automatic logic [SAMPLE_W-1:0] weighted_mean(input logic [SAMPLE_W-1:0] centre,
      input logic [3:0] present, input logic [SAMPLE_W-1:0] left, right, up, down);
    int sum;
    int divisor;
    divisor = pred_weight;
    sum = divisor * centre;
    if (present[0]) begin
      sum += left;
      divisor++;
    end
    if (present[1]) begin
      sum += right;
      divisor++;
    end
    if (present[2]) begin
      sum += up;
      divisor++;
    end
    if (present[3]) begin
      sum += down;
      divisor++;
    end
    if (divisor == 0) return '0;
    return SAMPLE_W'(sum / divisor);
  endfunction

  task automatic predict_smoothed(input logic [SAMPLE_W-1:0] height);
    int cols;
    int rows;
    int c;
    int r;
    logic [SAMPLE_W-1:0] older;
    logic [SAMPLE_W-1:0] held;
    cell_result_t expected_item;
    cols = cols_in_use();
    rows = rows_in_use();
    c = (next_col >= cols) ? cols - 1 : next_col;
    r = (next_row >= rows) ? rows - 1 : next_row;
    older = curr_line[c];
    curr_line[c] = height;
    if (r >= 1) begin
      expected_item.smoothed = weighted_mean(prev_line[c],
                                             {1'b1, r >= 2, c + 1 < cols, c > 0},
                                             (c > 0) ? prev_line[c - 1] : 8'd0,
                                             (c + 1 < cols) ? prev_line[c + 1] : 8'd0,
                                             older, height);
      expected_item.last_cell = 1'b0;
      queue_expected(expected_item);
    end
    if (c + 1 >= cols) begin
      if (r + 1 >= rows) begin
        for (int k = 0; k < cols; k++) begin
          expected_item.smoothed = weighted_mean(curr_line[k],
                                                 {1'b0, r >= 1, k + 1 < cols, k > 0},
                                                 (k > 0) ? curr_line[k - 1] : 8'd0,
                                                 (k + 1 < cols) ? curr_line[k + 1] : 8'd0,
                                                 prev_line[k], 8'd0);
          expected_item.last_cell = (k + 1 == cols);
          queue_expected(expected_item);
        end
        next_row = 0;
      end else begin
        for (int k = 0; k < LINE_CELLS; k++) begin
          held = prev_line[k];
          prev_line[k] = curr_line[k];
          curr_line[k] = held;
        end
        next_row = r + 1;
      end
      next_col = 0;
    end else begin
      next_col = c + 1;
      next_row = r;
    end
  endtask

  // Starts at the falling edge after the previous transfer and returns at the accepting edge.
  task automatic send_sample(input logic [SAMPLE_W-1:0] height);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= height;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_smoothed(height);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_NUM_COLS:      pred_cols = data[NUM_COLS_W-1:0];
      CFG_NUM_ROWS:      pred_rows = data[NUM_ROWS_W-1:0];
      CFG_CENTER_WEIGHT: pred_weight = data[WEIGHT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure_grid(input logic [NUM_COLS_W-1:0] cols,
                                input logic [NUM_ROWS_W-1:0] rows,
                                input logic [WEIGHT_W-1:0] weight);
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom;
    write_reg(CFG_NUM_COLS, {junk[CFG_DATA_W-1:NUM_COLS_W], cols});
    write_reg(CFG_NUM_ROWS, rows);
    junk = $urandom;
    write_reg(CFG_CENTER_WEIGHT, {junk[CFG_DATA_W-1:WEIGHT_W], weight});
    if ($urandom_range(7) == 0) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
  endtask

  // Lowers in_valid, waits for every expected result, then lets the core settle.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] random_height();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_grid(input fill_t fill);
    int rows;
    int cols;
    logic [SAMPLE_W-1:0] height;
    rows = rows_in_use();
    cols = cols_in_use();
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        case (fill)
          FILL_MAX:     height = '1;
          FILL_ZERO:    height = '0;
          FILL_CHECKER: height = ((r + c) % 2 == 1) ? 8'hFF : 8'h00;
          default:      height = random_height();
        endcase
        send_sample(height);
      end
    end
    wait_idle();
  endtask

  task automatic test_reset_defaults();
    write_reg(CFG_NUM_ROWS, 13'd1);
    send_grid(FILL_RANDOM);
  endtask

  task automatic test_single_cell();
    configure_grid(6'd1, 13'd1, 4'd0);
    send_grid(FILL_MAX);
    configure_grid(6'd0, 13'd0, 4'd0);
    send_grid(FILL_RANDOM);
    configure_grid(6'd1, 13'd1, 4'd15);
    send_grid(FILL_MAX);
    send_grid(FILL_ZERO);
  endtask

  task automatic test_extremes();
    configure_grid(6'd3, 13'd3, 4'd15);
    send_grid(FILL_CHECKER);
    configure_grid(6'd2, 13'd2, 4'd15);
    send_grid(FILL_MAX);
    configure_grid(6'd3, 13'd2, 4'd0);
    send_grid(FILL_CHECKER);
  endtask

  task automatic test_column_clamp();
    configure_grid(6'd63, 13'd1, 4'd1);
    send_grid(FILL_CHECKER);
  endtask

  // A row count above the limit keeps the grid open; a smaller count then ends it.
  task automatic test_row_clamp();
    configure_grid(6'd1, 13'd8191, 4'($urandom));
    for (int i = 0; i < 12; i++) send_sample(random_height());
    wait_idle();
    write_reg(CFG_NUM_ROWS, 13'd12);
    send_sample(random_height());
    wait_idle();
  endtask

  task automatic test_output_backpressure();
    configure_grid(6'd8, 13'd6, 4'd3);
    for (int i = 0; i < 8; i++) send_sample(random_height());
    fork
      begin
        hold_output = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
      end
    join_none
    for (int i = 8; i < 48; i++) send_sample(random_height());
    wait_idle();
  endtask

  task automatic test_random_grids(input int target_items);
    int sent;
    logic [NUM_COLS_W-1:0] cols;
    logic [NUM_ROWS_W-1:0] rows;
    sent = 0;
    while (sent < target_items) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5, 6: cols = 6'($urandom_range(1, 8));
        7, 8: cols = 6'($urandom_range(9, 32));
        default: cols = ($urandom_range(1) == 0) ? 6'd0 : 6'($urandom_range(33, 63));
      endcase
      rows = ($urandom_range(9) == 0) ? 13'd0 : 13'($urandom_range(1, (cols < 6) ? 12 : 5));
      configure_grid(cols, rows, 4'($urandom));
      sent += cols_in_use() * rows_in_use();
      send_grid(FILL_RANDOM);
    end
  endtask

  initial begin
    for (int k = 0; k < LINE_CELLS; k++) begin
      prev_line[k] = '0;
      curr_line[k] = '0;
    end
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 19;
    recv_idle_pct = 47;
    test_reset_defaults();
    test_single_cell();
    test_extremes();
    test_column_clamp();
    test_output_backpressure();
    test_random_grids(80);

    send_idle_pct = 47;
    recv_idle_pct = 19;
    test_random_grids(80);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_grids(80);
    test_row_clamp();

    if (pending_cells.size() != 0) begin
      $error("%0d expected results never arrived", pending_cells.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("** cross_stencil_height_smoother_core: PASSED **");
    end else begin
      $display("** cross_stencil_height_smoother_core: FAILED **");
    end
    $finish;
  end

endmodule
